@@ sv/pimc_pkg.sv @@
// ----------------------------------------------------------------------------
// pimc_pkg
// Shared constants and codes for the pair invariant mass classifier.
// ----------------------------------------------------------------------------
package pimc_pkg;

  localparam int unsigned MOMENTUM_BITS_DEF = 24;
  localparam int unsigned FRACTION_BITS_DEF = 12;

  localparam int unsigned MASS_HYP_W  = 16;
  localparam int unsigned MATCH_WIN_W = 23;
  localparam int unsigned PAIR_MASS_W = 26;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 23;

  localparam longint unsigned HIGH_PT_GEV = 2;

  localparam logic [MATCH_WIN_W-1:0] MATCH_WIN_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS_HYP  = 2'd0,
    CFG_MATCH_WIN = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    MC_NONE  = 2'd0,
    MC_ONE   = 2'd1,
    MC_BOTH  = 2'd2,
    MC_OTHER = 2'd3
  } match_class_e;

endpackage

@@ sv/pimc_isqrt.sv @@
// ----------------------------------------------------------------------------
// pimc_isqrt
// Pipelined floor square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module pimc_isqrt #(
  parameter int unsigned RadW = 2 * pimc_pkg::MOMENTUM_BITS_DEF + 2
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RadW-1:0]   rad_i,
  output logic [RadW/2-1:0] root_o
);

  localparam int unsigned N = RadW / 2;

  logic [RadW-1:0] rad_q  [N];
  logic [N+1:0]    rem_q  [N];
  logic [N-1:0]    root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RadW-1:0] rad_in;
    logic [N+1:0]    rem_in;
    logic [N-1:0]    root_in;
    logic [N+1:0]    rem_sh;
    logic [N+1:0]    trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // remainder stays below 2^N before the shift
    always_comb begin
      rem_sh = {rem_in[N-1:0], rad_in[RadW-1 -: 2]};
      trial  = {root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[N-2:0], ge};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

@@ sv/pair_invariant_mass_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// pair_invariant_mass_classifier_unit
// Two-body invariant mass and electron match class of a track pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one track pair per item.
//   Pairs whose charges are not opposite are dropped and give no result.
//   Output channel (out_valid_o / out_ready_i) gives pair_mass, the negative
//   mass flag, the high-pt flag and the match class.
//   Config channel (cfg_valid_i / cfg_ready_o) writes mass_hypothesis (index
//   0) or match_window (index 1); other indexes are ignored. Always ready;
//   write only while the block is idle.
// Timing:
//   One item per cycle sustained while the output is not stalled. Each item
//   passes the input and multiply stages, the two bit-per-stage square root
//   pipelines (energies, then mass) and the output register.
// Reset:
//   Clears all valid bits, empties the output and skid registers and loads
//   the register reset values. No clearing pass.
// Stall:
//   When out_ready_i is low one more result is caught in a skid register;
//   the pipeline then freezes and in_ready_o drops until it drains.
// ----------------------------------------------------------------------------
module pair_invariant_mass_classifier_unit #(
  parameter int unsigned MomentumBits = pimc_pkg::MOMENTUM_BITS_DEF,
  parameter int unsigned FractionBits = pimc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pimc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pimc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [MomentumBits-1:0]         px_a_i,
  input  logic signed [MomentumBits-1:0]         py_a_i,
  input  logic signed [MomentumBits-1:0]         pz_a_i,
  input  logic signed [1:0]                      charge_a_i,
  input  logic                                   elec_a_i,
  input  logic signed [MomentumBits-1:0]         dp_a_i,
  input  logic signed [MomentumBits-1:0]         px_b_i,
  input  logic signed [MomentumBits-1:0]         py_b_i,
  input  logic signed [MomentumBits-1:0]         pz_b_i,
  input  logic signed [1:0]                      charge_b_i,
  input  logic                                   elec_b_i,
  input  logic signed [MomentumBits-1:0]         dp_b_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [pimc_pkg::PAIR_MASS_W-1:0]       pair_mass_o,
  output logic                                   mass_negative_o,
  output logic                                   both_high_pt_o,
  output logic [1:0]                             match_class_o
);

  import pimc_pkg::*;

  localparam int unsigned MB    = MomentumBits;
  localparam int unsigned SQ_W  = 2 * MB;        // one component squared
  localparam int unsigned RAD_W = 2 * MB + 2;    // energy radicand, p2
  localparam int unsigned EW    = RAD_W / 2;     // energy width
  localparam int unsigned ET_W  = EW + 1;        // energy sum
  localparam int unsigned MR_W  = 2 * ET_W;      // mass radicand
  localparam int unsigned MW    = MR_W / 2;      // mass root width
  localparam int unsigned CMP_W = MB + MATCH_WIN_W;
  localparam longint unsigned THR  = HIGH_PT_GEV << FractionBits;
  localparam longint unsigned THR2 = THR * THR;

  // ---------------- config registers ----------------
  logic [MASS_HYP_W-1:0]  mass_hyp_q;
  logic [MATCH_WIN_W-1:0] match_win_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_hyp_q  <= '0;
      match_win_q <= MATCH_WIN_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MASS_HYP) begin
        mass_hyp_q <= cfg_data_i[MASS_HYP_W-1:0];
      end else if (cfg_index_i == CFG_MATCH_WIN) begin
        match_win_q <= cfg_data_i[MATCH_WIN_W-1:0];
      end
    end
  end

  // ---------------- flow control ----------------
  // whole pipeline moves unless the skid register holds a result
  logic en;
  logic skid_v_q;

  assign en         = ~skid_v_q;
  assign in_ready_o = en;

  // ---------------- stage 0: input capture ----------------
  logic opposite;
  assign opposite = (charge_a_i[1] && charge_b_i == 2'sd1) ||
                    (charge_a_i == 2'sd1 && charge_b_i[1]);

  logic signed [MB-1:0] comp_q [6];   // xa ya za xb yb zb
  logic signed [MB-1:0] dpa_q, dpb_q;
  logic                 ea_q, eb_q;
  logic                 v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i & opposite;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      comp_q[0] <= px_a_i;
      comp_q[1] <= py_a_i;
      comp_q[2] <= pz_a_i;
      comp_q[3] <= px_b_i;
      comp_q[4] <= py_b_i;
      comp_q[5] <= pz_b_i;
      dpa_q     <= dp_a_i;
      dpb_q     <= dp_b_i;
      ea_q      <= elec_a_i;
      eb_q      <= elec_b_i;
    end
  end

  // ---------------- stage 1: squares, sums, window ----------------
  logic [MB-1:0]        cmag [6];
  logic [SQ_W-1:0]      sq1_q [6];
  logic signed [MB:0]   sum_d [3];
  logic signed [MB:0]   sum1_q [3];
  logic [2*MASS_HYP_W-1:0] m2_q;
  logic [MB-1:0]        dpa_mag, dpb_mag;
  logic                 wa, wb;
  match_class_e         cls_d, cls1_q;
  logic                 v1_q;

  for (genvar i = 0; i < 6; i++) begin : g_cmag
    assign cmag[i] = comp_q[i][MB-1] ? (~comp_q[i] + 1'b1) : comp_q[i];
  end
  for (genvar j = 0; j < 3; j++) begin : g_sum
    assign sum_d[j] = {comp_q[j][MB-1], comp_q[j]} + {comp_q[j+3][MB-1], comp_q[j+3]};
  end

  assign dpa_mag = dpa_q[MB-1] ? (~dpa_q + 1'b1) : dpa_q;
  assign dpb_mag = dpb_q[MB-1] ? (~dpb_q + 1'b1) : dpb_q;
  assign wa = ea_q && (CMP_W'(dpa_mag) <= CMP_W'(match_win_q));
  assign wb = eb_q && (CMP_W'(dpb_mag) <= CMP_W'(match_win_q));

  always_comb begin
    if (!ea_q && !eb_q) begin
      cls_d = MC_NONE;
    end else if ((wa && !eb_q) || (!ea_q && wb)) begin
      cls_d = MC_ONE;
    end else if (wa && wb) begin
      cls_d = MC_BOTH;
    end else begin
      cls_d = MC_OTHER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sq1_q[i] <= cmag[i] * cmag[i];
      end
      for (int j = 0; j < 3; j++) begin
        sum1_q[j] <= sum_d[j];
      end
      m2_q   <= mass_hyp_q * mass_hyp_q;
      cls1_q <= cls_d;
    end
  end

  // ---------------- stage 2: radicands, pt test, sum squares ----------------
  logic [SQ_W:0]     pta2, ptb2;
  logic [MB:0]       smag [3];
  logic [RAD_W-1:0]  ra2_q, rb2_q;
  logic [RAD_W-1:0]  ss2_q [3];
  logic              high2_q;
  match_class_e      cls2_q;
  logic              v2_q;

  assign pta2 = {1'b0, sq1_q[0]} + {1'b0, sq1_q[1]};
  assign ptb2 = {1'b0, sq1_q[3]} + {1'b0, sq1_q[4]};

  for (genvar j = 0; j < 3; j++) begin : g_smag
    assign smag[j] = sum1_q[j][MB] ? (~sum1_q[j] + 1'b1) : sum1_q[j];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra2_q   <= RAD_W'(m2_q) + RAD_W'(pta2) + RAD_W'(sq1_q[2]);
      rb2_q   <= RAD_W'(m2_q) + RAD_W'(ptb2) + RAD_W'(sq1_q[5]);
      for (int j = 0; j < 3; j++) begin
        ss2_q[j] <= smag[j] * smag[j];
      end
      high2_q <= (64'(pta2) >= THR2) && (64'(ptb2) >= THR2);
      cls2_q  <= cls1_q;
    end
  end

  // ---------------- stage 3: total momentum squared ----------------
  logic [RAD_W-1:0] ra3_q, rb3_q, p2_3_q;
  logic             high3_q;
  match_class_e     cls3_q;
  logic             v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra3_q   <= ra2_q;
      rb3_q   <= rb2_q;
      p2_3_q  <= ss2_q[0] + ss2_q[1] + ss2_q[2];
      high3_q <= high2_q;
      cls3_q  <= cls2_q;
    end
  end

  // ---------------- energy roots, sideband delay ----------------
  logic [EW-1:0] en_a, en_b;

  pimc_isqrt #(.RadW(RAD_W)) u_sqrt_ea (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (ra3_q),
    .root_o (en_a)
  );

  pimc_isqrt #(.RadW(RAD_W)) u_sqrt_eb (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rb3_q),
    .root_o (en_b)
  );

  logic [RAD_W-1:0] de_p2_q   [EW];
  logic             de_high_q [EW];
  match_class_e     de_cls_q  [EW];
  logic             de_v_q    [EW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < EW; k++) begin
        de_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      de_v_q[0] <= v3_q;
      for (int k = 1; k < EW; k++) begin
        de_v_q[k] <= de_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      de_p2_q[0]   <= p2_3_q;
      de_high_q[0] <= high3_q;
      de_cls_q[0]  <= cls3_q;
      for (int k = 1; k < EW; k++) begin
        de_p2_q[k]   <= de_p2_q[k-1];
        de_high_q[k] <= de_high_q[k-1];
        de_cls_q[k]  <= de_cls_q[k-1];
      end
    end
  end

  // ---------------- energy sum, square, difference ----------------
  logic [ET_W-1:0]  etot_q;
  logic [RAD_W-1:0] p2e_q, p2m_q;
  logic [MR_W-1:0]  e2_q, mrad_q;
  logic             highe_q, highm_q, highd_q;
  match_class_e     clse_q, clsm_q, clsd_q;
  logic             ve_q, vm_q, vd_q;
  logic             negd_q;
  logic             neg_d;

  assign neg_d = e2_q < MR_W'(p2m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vm_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      ve_q <= de_v_q[EW-1];
      vm_q <= ve_q;
      vd_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      etot_q  <= ET_W'(en_a) + ET_W'(en_b);
      p2e_q   <= de_p2_q[EW-1];
      highe_q <= de_high_q[EW-1];
      clse_q  <= de_cls_q[EW-1];

      e2_q    <= etot_q * etot_q;
      p2m_q   <= p2e_q;
      highm_q <= highe_q;
      clsm_q  <= clse_q;

      negd_q  <= neg_d;
      mrad_q  <= neg_d ? '0 : (e2_q - MR_W'(p2m_q));
      highd_q <= highm_q;
      clsd_q  <= clsm_q;
    end
  end

  // ---------------- mass root, sideband delay ----------------
  logic [MW-1:0] mass_root;

  pimc_isqrt #(.RadW(MR_W)) u_sqrt_mass (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (mrad_q),
    .root_o (mass_root)
  );

  logic         dm_neg_q  [MW];
  logic         dm_high_q [MW];
  match_class_e dm_cls_q  [MW];
  logic         dm_v_q    [MW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MW; k++) begin
        dm_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      dm_v_q[0] <= vd_q;
      for (int k = 1; k < MW; k++) begin
        dm_v_q[k] <= dm_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_neg_q[0]  <= negd_q;
      dm_high_q[0] <= highd_q;
      dm_cls_q[0]  <= clsd_q;
      for (int k = 1; k < MW; k++) begin
        dm_neg_q[k]  <= dm_neg_q[k-1];
        dm_high_q[k] <= dm_high_q[k-1];
        dm_cls_q[k]  <= dm_cls_q[k-1];
      end
    end
  end

  // ---------------- output register and skid ----------------
  // mass is cut or padded to the port width
  logic [MW+PAIR_MASS_W-1:0] mass_ext;
  logic [PAIR_MASS_W-1:0]    last_mass;
  logic                      last_v;

  assign mass_ext  = (MW + PAIR_MASS_W)'(mass_root);
  assign last_mass = mass_ext[PAIR_MASS_W-1:0];
  assign last_v    = dm_v_q[MW-1];

  logic                   out_v_q;
  logic [PAIR_MASS_W-1:0] out_mass_q, skid_mass_q;
  logic                   out_neg_q, skid_neg_q;
  logic                   out_high_q, skid_high_q;
  match_class_e           out_cls_q, skid_cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en && last_v) begin
      if (!out_v_q || out_ready_i) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_v_q && out_ready_i) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_v) begin
      if (!out_v_q || out_ready_i) begin
        out_mass_q <= last_mass;
        out_neg_q  <= dm_neg_q[MW-1];
        out_high_q <= dm_high_q[MW-1];
        out_cls_q  <= dm_cls_q[MW-1];
      end else begin
        skid_mass_q <= last_mass;
        skid_neg_q  <= dm_neg_q[MW-1];
        skid_high_q <= dm_high_q[MW-1];
        skid_cls_q  <= dm_cls_q[MW-1];
      end
    end else if (out_v_q && out_ready_i && skid_v_q) begin
      out_mass_q <= skid_mass_q;
      out_neg_q  <= skid_neg_q;
      out_high_q <= skid_high_q;
      out_cls_q  <= skid_cls_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign pair_mass_o     = out_mass_q;
  assign mass_negative_o = out_neg_q;
  assign both_high_pt_o  = out_high_q;
  assign match_class_o   = out_cls_q;

endmodule
